>>> design/top_pkg.sv
`default_nettype none
package top_pkg;
    localparam int DELTA_WIDTH = 20;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int PHASE_WIDTH = 2;
    localparam logic [PHASE_WIDTH-1:0] PHASE_UP     = 2'd0;
    localparam logic [PHASE_WIDTH-1:0] PHASE_CRUISE = 2'd1;
    localparam logic [PHASE_WIDTH-1:0] PHASE_DOWN   = 2'd2;
    localparam logic [PHASE_WIDTH-1:0] PHASE_DONE   = 2'd3;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_START = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_END   = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOTAL = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UP    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DOWN  = 3'd4;

    typedef struct packed {
        logic load;
        logic divide;
        logic blend;
    } top_cmd_t;

    typedef struct packed {
        logic div_done;
        logic blend_done;
    } top_status_t;
endpackage
`default_nettype wire

>>> design/top_if.sv
`default_nettype none
interface top_tick_if #(parameter int W = 20);
    logic valid;
    logic ready;
    logic [W-1:0] delta_time;
    modport source (output valid, output delta_time, input ready);
    modport sink (input valid, input delta_time, output ready);
endinterface

interface top_result_if #(parameter int W = 20);
    logic valid;
    logic ready;
    logic signed [W-1:0] orient_x;
    logic signed [W-1:0] orient_y;
    logic signed [W-1:0] orient_z;
    logic [1:0] phase;
    logic finished;
    logic config_error;
    modport source (output valid, output orient_x, output orient_y, output orient_z,
        output phase, output finished, output config_error, input ready);
    modport sink (input valid, input orient_x, input orient_y, input orient_z,
        input phase, input finished, input config_error, output ready);
endinterface
`default_nettype wire

>>> design/top_ctrl.sv
`default_nettype none
module top_ctrl
    import top_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output top_cmd_t         cmd,
    input  wire top_status_t status
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_BLND = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.divide = 1'b1;
                if (status.div_done)
                    state_next = S_BLND;
            end
            S_BLND:
            begin
                cmd.blend = 1'b1;
                if (status.blend_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("input taken while busy");
    a_load_to_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg == S_DIV)
        else $error("load did not start division");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
`endif
endmodule
`default_nettype wire

>>> design/top_datapath.sv
`default_nettype none
module top_datapath
    import top_pkg::*;
#(
    parameter int ANGLE_WIDTH = 20,
    parameter int TIME_WIDTH = 26,
    parameter int PROGRESS_FRAC_BITS = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire top_cmd_t                   cmd,
    output top_status_t                     status,
    input  wire logic [DELTA_WIDTH-1:0]     delta_time,
    input  wire logic [3*ANGLE_WIDTH-1:0]   start_o,
    input  wire logic [3*ANGLE_WIDTH-1:0]   end_o,
    input  wire logic [TIME_WIDTH-1:0]      tt,
    input  wire logic [TIME_WIDTH-1:0]      tu,
    input  wire logic [TIME_WIDTH-1:0]      td,
    output logic signed [ANGLE_WIDTH-1:0]   orient_x,
    output logic signed [ANGLE_WIDTH-1:0]   orient_y,
    output logic signed [ANGLE_WIDTH-1:0]   orient_z,
    output logic [PHASE_WIDTH-1:0]          phase,
    output logic                            config_error
);
    // Operand width: products of two times plus sign and headroom.
    localparam int EW = TIME_WIDTH + 1;
    localparam int NW = 2 * EW + 4;
    localparam int MW = EW + 3;
    localparam int FW = PROGRESS_FRAC_BITS + 1;
    localparam int CW = $clog2(NW + PROGRESS_FRAC_BITS + 2) + 1;
    localparam logic [EW-1:0] ELAPSED_MAX = {EW{1'b1}};
    localparam int BW = ANGLE_WIDTH + 2 + FW;
    localparam logic [FW-1:0] FRAC_ONE = FW'(1) << PROGRESS_FRAC_BITS;

    logic [EW-1:0] elapsed_reg;
    logic [PHASE_WIDTH-1:0] phase_reg;
    logic signed [EW+1:0] pden_reg;
    logic signed [NW-1:0] num_reg, den_reg;
    logic force_one_reg;
    logic fresh_reg;
    logic div_done_reg, blend_done_reg;
    logic [NW-1:0] rem_reg, dsh_reg;
    logic [FW-1:0] frac_reg;
    logic [CW-1:0] cnt_reg;
    logic [1:0] sub_reg;
    logic [1:0] axis_reg;
    logic signed [ANGLE_WIDTH-1:0] res_reg [3];

    logic signed [EW+2:0] t_s, T_s, U_s, D_s, tp_s;
    logic [EW:0] sum_e;
    logic [EW-1:0] elapsed_new;
    logic signed [EW+1:0] pden_new;
    logic div_fin, blend_fin;

    assign sum_e = (elapsed_reg == '0 ? {(EW+1){1'b0}} : {1'b0, elapsed_reg})
        + (EW+1)'(delta_time);
    assign elapsed_new = sum_e[EW] ? ELAPSED_MAX : sum_e[EW-1:0];
    assign pden_new = (EW+2)'(2 * $signed({1'b0, tt}))
        - (EW+2)'($signed({1'b0, tu})) - (EW+2)'($signed({1'b0, td}));
    assign t_s = $signed({3'b0, elapsed_reg});
    assign T_s = $signed({4'b0, tt});
    assign U_s = $signed({4'b0, tu});
    assign D_s = $signed({4'b0, td});
    assign tp_s = t_s - (T_s - D_s);
    assign config_error = ({1'b0, tu} + {1'b0, td}) > {1'b0, tt};

    // One multiply per setup step through a single shared multiplier.
    logic signed [MW-1:0] mul_a, mul_b;
    logic signed [2*MW-1:0] prod;
    logic signed [NW-1:0] p1_reg;
    assign prod = mul_a * mul_b;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (phase_reg)
            PHASE_UP:
            begin
                if (sub_reg == 2'd0)
                begin
                    mul_a = t_s;
                    mul_b = t_s;
                end
                else
                begin
                    mul_a = U_s;
                    mul_b = MW'(pden_reg);
                end
            end
            PHASE_DOWN:
            begin
                if (sub_reg == 2'd0)
                begin
                    mul_a = D_s;
                    mul_b = MW'(2 * T_s - U_s - 2 * D_s + 2 * tp_s);
                end
                else if (sub_reg == 2'd1)
                begin
                    mul_a = tp_s;
                    mul_b = tp_s;
                end
                else
                begin
                    mul_a = D_s;
                    mul_b = MW'(pden_reg);
                end
            end
            default: ;
        endcase
    end

    logic [NW:0] trial;
    assign trial = {rem_reg, 1'b0} - {1'b0, dsh_reg};

    assign div_fin = cmd.divide && !div_done_reg
        && ((cnt_reg == CW'(1) && (force_one_reg || num_reg <= 0 || den_reg <= 0
                                   || num_reg >= den_reg))
            || cnt_reg == CW'(PROGRESS_FRAC_BITS + 1));
    assign blend_fin = cmd.blend && !blend_done_reg && (axis_reg == 2'd2);
    assign status = {div_done_reg, blend_done_reg};

    // One axis per cycle: start + round((end - start) * f).
    logic signed [ANGLE_WIDTH-1:0] sa, ea;
    logic signed [ANGLE_WIDTH:0] diff;
    logic signed [BW-1:0] bsum;
    logic signed [ANGLE_WIDTH-1:0] blend_v;
    always_comb
    begin
        sa = start_o[axis_reg*ANGLE_WIDTH +: ANGLE_WIDTH];
        ea = end_o[axis_reg*ANGLE_WIDTH +: ANGLE_WIDTH];
        diff = (ANGLE_WIDTH+1)'(ea) - (ANGLE_WIDTH+1)'(sa);
        bsum = BW'(diff) * $signed({1'b0, frac_reg})
            + (BW'(1) <<< (PROGRESS_FRAC_BITS - 1));
        blend_v = sa + ANGLE_WIDTH'(bsum >>> PROGRESS_FRAC_BITS);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg <= '0;
            phase_reg <= PHASE_UP;
            sub_reg <= '0;
            cnt_reg <= '0;
            axis_reg <= '0;
            fresh_reg <= 1'b0;
            force_one_reg <= 1'b0;
            div_done_reg <= 1'b0;
            blend_done_reg <= 1'b0;
        end
        else
        begin
            div_done_reg <= div_fin;
            blend_done_reg <= blend_fin;
            if (cmd.load)
            begin
                if (elapsed_reg == '0)
                begin
                    pden_reg <= pden_new;
                    phase_reg <= PHASE_UP;
                end
                elapsed_reg <= elapsed_new;
                sub_reg <= '0;
                cnt_reg <= '0;
                axis_reg <= '0;
                fresh_reg <= 1'b1;
                force_one_reg <= 1'b0;
            end
            else if (cmd.divide && !div_done_reg)
            begin
                if (cnt_reg == '0)
                begin
                    // Setup: pick the phase, form numerator and denominator.
                    unique case (phase_reg)
                        PHASE_UP:
                        begin
                            if (t_s >= U_s)
                            begin
                                phase_reg <= PHASE_CRUISE;
                                num_reg <= NW'(2 * t_s - U_s);
                                den_reg <= NW'(pden_reg);
                                cnt_reg <= CW'(1);
                            end
                            else if (sub_reg == 2'd0)
                            begin
                                p1_reg <= NW'(prod);
                                sub_reg <= 2'd1;
                            end
                            else
                            begin
                                num_reg <= p1_reg;
                                den_reg <= NW'(prod);
                                cnt_reg <= CW'(1);
                            end
                        end
                        PHASE_CRUISE:
                        begin
                            if (t_s >= T_s - D_s)
                            begin
                                phase_reg <= PHASE_DOWN;
                                sub_reg <= '0;
                                fresh_reg <= 1'b0;
                            end
                            else
                            begin
                                num_reg <= NW'(2 * t_s - U_s);
                                den_reg <= NW'(pden_reg);
                                cnt_reg <= CW'(1);
                            end
                        end
                        PHASE_DOWN:
                        begin
                            // The end check applies only to a tick that began in
                            // ramp down, not to one that just entered it.
                            if (sub_reg == 2'd0 && fresh_reg && t_s >= T_s)
                            begin
                                phase_reg <= PHASE_DONE;
                                force_one_reg <= 1'b1;
                                cnt_reg <= CW'(1);
                            end
                            else if (sub_reg == 2'd0)
                            begin
                                p1_reg <= NW'(prod);
                                sub_reg <= 2'd1;
                            end
                            else if (sub_reg == 2'd1)
                            begin
                                num_reg <= p1_reg - NW'(prod);
                                sub_reg <= 2'd2;
                            end
                            else
                            begin
                                den_reg <= NW'(prod);
                                force_one_reg <= (td == '0);
                                cnt_reg <= CW'(1);
                            end
                        end
                        default:
                        begin
                            force_one_reg <= 1'b1;
                            cnt_reg <= CW'(1);
                        end
                    endcase
                end
                else if (cnt_reg == CW'(1))
                begin
                    // Clamp cases, then start the restoring divider.
                    rem_reg <= num_reg;
                    dsh_reg <= den_reg;
                    if (force_one_reg)
                        frac_reg <= FRAC_ONE;
                    else if (num_reg <= 0 || den_reg <= 0)
                        frac_reg <= '0;
                    else if (num_reg >= den_reg)
                        frac_reg <= FRAC_ONE;
                    else
                    begin
                        frac_reg <= '0;
                        cnt_reg <= CW'(2);
                    end
                end
                else
                begin
                    if (!trial[NW])
                    begin
                        rem_reg <= trial[NW-1:0];
                        frac_reg <= {frac_reg[FW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= {rem_reg[NW-2:0], 1'b0};
                        frac_reg <= {frac_reg[FW-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + CW'(1);
                end
            end
            else if (cmd.blend && !blend_done_reg)
            begin
                res_reg[axis_reg] <= blend_v;
                axis_reg <= (axis_reg == 2'd2) ? 2'd0 : axis_reg + 2'd1;
            end
        end
    end

    assign orient_x = res_reg[0];
    assign orient_y = res_reg[1];
    assign orient_z = res_reg[2];
    assign phase = phase_reg;
endmodule
`default_nettype wire

>>> design/trapezoid_orientation_profile_unit.sv
`default_nettype none
// Each tick transaction adds its delta to the elapsed time and yields one result
// transaction with the blended orientation, phase and flags. A tick passes through
// the accepting step, up to four setup steps through one shared multiplier, a
// clamp check, the restoring divider at one quotient bit per cycle, a handover,
// three blend steps (one per axis) and a handover, and the output step. When the
// fraction clamps to zero or one, or the move is done, the divider is skipped.
// One tick is handled at a time; the result waits in its register until taken.
module trapezoid_orientation_profile_unit
    import top_pkg::*;
#(
    parameter int ANGLE_WIDTH = 20,
    parameter int TIME_WIDTH = 26,
    parameter int PROGRESS_FRAC_BITS = 16
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    top_tick_if.sink                          tick,
    top_result_if.source                      result,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [3*ANGLE_WIDTH-1:0]     cfg_data
);
    logic [3*ANGLE_WIDTH-1:0] start_reg, end_reg;
    logic [TIME_WIDTH-1:0] total_reg, up_reg, down_reg;
    top_cmd_t cmd;
    top_status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= '0;
            end_reg <= '0;
            total_reg <= TIME_WIDTH'(1000000);
            up_reg <= TIME_WIDTH'(250000);
            down_reg <= TIME_WIDTH'(250000);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_START: start_reg <= cfg_data;
                REG_END:   end_reg <= cfg_data;
                REG_TOTAL: total_reg <= cfg_data[TIME_WIDTH-1:0];
                REG_UP:    up_reg <= cfg_data[TIME_WIDTH-1:0];
                REG_DOWN:  down_reg <= cfg_data[TIME_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    top_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(tick.valid), .in_ready(tick.ready),
        .out_valid(result.valid), .out_ready(result.ready),
        .cmd(cmd), .status(status)
    );

    top_datapath #(
        .ANGLE_WIDTH(ANGLE_WIDTH),
        .TIME_WIDTH(TIME_WIDTH), .PROGRESS_FRAC_BITS(PROGRESS_FRAC_BITS)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
        .delta_time(tick.delta_time),
        .start_o(start_reg), .end_o(end_reg),
        .tt(total_reg), .tu(up_reg), .td(down_reg),
        .orient_x(result.orient_x), .orient_y(result.orient_y),
        .orient_z(result.orient_z), .phase(result.phase),
        .config_error(result.config_error)
    );
    assign result.finished = (result.phase == PHASE_DONE);
endmodule
`default_nettype wire

>>> tb/sv/tb_trapezoid_orientation_profile_unit.sv
`default_nettype none

typedef struct {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [19:0] z;
    logic [1:0]         ph;
    logic               fin;
    logic               err;
} orient_sample_t;

class orient_scoreboard;
    localparam longint FRAC_ONE = 64'd1 << 16;
    localparam longint ELAPSED_LIMIT = (64'd1 << 27) - 1;

    logic [59:0] start_o;
    logic [59:0] end_o;
    longint total_us;
    longint up_us;
    longint down_us;

    longint elapsed_us;
    logic [1:0] move_ph;
    longint denom;

    orient_sample_t pending[$];
    int errors;

    function new();
        start_o = '0;
        end_o = '0;
        total_us = 1000000;
        up_us = 250000;
        down_us = 250000;
        elapsed_us = 0;
        move_ph = top_pkg::PHASE_UP;
        denom = 0;
        errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [59:0] val);
        case (idx)
            top_pkg::REG_START: start_o = val;
            top_pkg::REG_END:   end_o = val;
            top_pkg::REG_TOTAL: total_us = val[25:0];
            top_pkg::REG_UP:    up_us = val[25:0];
            top_pkg::REG_DOWN:  down_us = val[25:0];
            default: ;
        endcase
    endfunction

    // Floor of num/den as a progress fraction, clamped to [0, 1].
    function longint progress(longint num, longint den);
        longint r;
        longint q;
        if (num <= 0 || den <= 0)
            return 0;
        if (num >= den)
            return FRAC_ONE;
        r = num;
        q = 0;
        for (int i = 0; i < 16; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= den)
            begin
                r = r - den;
                q = q | 1;
            end
        end
        return q;
    endfunction

    function longint down_progress(longint tp);
        if (down_us == 0)
            return FRAC_ONE;
        return progress(down_us * (2 * total_us - up_us - 2 * down_us + 2 * tp) - tp * tp,
                        down_us * denom);
    endfunction

    function logic [19:0] mix(int axis, longint f);
        logic signed [19:0] av;
        logic signed [19:0] bv;
        longint a;
        longint b;
        longint sum;
        av = start_o[axis*20 +: 20];
        bv = end_o[axis*20 +: 20];
        a = av;
        b = bv;
        sum = (a + 524288) * FRAC_ONE + (b - a) * f + (FRAC_ONE >> 1);
        return 20'((sum >>> 16) - 524288);
    endfunction

    function void note_tick(logic [19:0] delta);
        longint t;
        longint tp;
        longint f;
        orient_sample_t e;
        if (elapsed_us == 0)
        begin
            denom = 2 * total_us - up_us - down_us;
            move_ph = top_pkg::PHASE_UP;
        end
        elapsed_us = elapsed_us + delta;
        if (elapsed_us > ELAPSED_LIMIT)
            elapsed_us = ELAPSED_LIMIT;
        t = elapsed_us;
        tp = t - (total_us - down_us);
        case (move_ph)
            top_pkg::PHASE_UP:
                if (t >= up_us)
                begin
                    f = progress(2 * t - up_us, denom);
                    move_ph = top_pkg::PHASE_CRUISE;
                end
                else
                    f = progress(t * t, up_us * denom);
            top_pkg::PHASE_CRUISE:
                if (t >= total_us - down_us)
                begin
                    f = down_progress(tp);
                    move_ph = top_pkg::PHASE_DOWN;
                end
                else
                    f = progress(2 * t - up_us, denom);
            top_pkg::PHASE_DOWN:
                if (t >= total_us)
                begin
                    f = FRAC_ONE;
                    move_ph = top_pkg::PHASE_DONE;
                end
                else
                    f = down_progress(tp);
            default:
                f = FRAC_ONE;
        endcase
        e.x = mix(0, f);
        e.y = mix(1, f);
        e.z = mix(2, f);
        e.ph = move_ph;
        e.fin = (move_ph == top_pkg::PHASE_DONE);
        e.err = (up_us + down_us > total_us);
        pending.push_back(e);
    endfunction

    function void check_result(orient_sample_t act);
        orient_sample_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: result transaction with nothing expected", $time);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (act.x !== e.x)
        begin
            $display("%0t: orient_x expected %0d actual %0d", $time, e.x, act.x);
            errors++;
        end
        if (act.y !== e.y)
        begin
            $display("%0t: orient_y expected %0d actual %0d", $time, e.y, act.y);
            errors++;
        end
        if (act.z !== e.z)
        begin
            $display("%0t: orient_z expected %0d actual %0d", $time, e.z, act.z);
            errors++;
        end
        if (act.ph !== e.ph)
        begin
            $display("%0t: phase expected %0d actual %0d", $time, e.ph, act.ph);
            errors++;
        end
        if (act.fin !== e.fin)
        begin
            $display("%0t: finished expected %0d actual %0d", $time, e.fin, act.fin);
            errors++;
        end
        if (act.err !== e.err)
        begin
            $display("%0t: config_error expected %0d actual %0d", $time, e.err, act.err);
            errors++;
        end
    endfunction
endclass

module tb_trapezoid_orientation_profile_unit;
    import top_pkg::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [59:0] cfg_data = '0;

    top_tick_if #(20) tick_bus ();
    top_result_if #(20) result_bus ();

    orient_scoreboard sb = new();
    bit steady = 1'b0;
    int hold_off = 0;

    trapezoid_orientation_profile_unit u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .tick(tick_bus.sink),
        .result(result_bus.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    initial
    begin
        tick_bus.valid = 1'b0;
        tick_bus.delta_time = '0;
        result_bus.ready = 1'b0;
    end

    // Receiver: random backpressure, or a counted hold-off when asked.
    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            result_bus.ready = 1'b0;
            hold_off = hold_off - 1;
        end
        else
            result_bus.ready = steady || ($urandom_range(0, 99) >= 37);
    end

    always @(posedge clk)
    begin
        orient_sample_t act;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            act.x = result_bus.orient_x;
            act.y = result_bus.orient_y;
            act.z = result_bus.orient_z;
            act.ph = result_bus.phase;
            act.fin = result_bus.finished;
            act.err = result_bus.config_error;
            sb.check_result(act);
        end
    end

    task automatic send_tick(logic [19:0] delta);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 37)
        begin
            tick_bus.valid = 1'b0;
            @(negedge clk);
        end
        tick_bus.valid = 1'b1;
        tick_bus.delta_time = delta;
        @(posedge clk);
        while (!tick_bus.ready)
            @(posedge clk);
        sb.note_tick(delta);
    endtask

    task automatic drain();
        @(negedge clk);
        tick_bus.valid = 1'b0;
        wait (sb.pending.size() == 0);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [59:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [59:0] rand_orient();
        logic [59:0] v;
        v = {$urandom, $urandom};
        return v;
    endfunction

    function automatic logic [19:0] rand_delta(int scale);
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return 20'hFFFFF;
        if (pick < 8)
            return '0;
        if (pick < 12)
            return 20'($urandom);
        return 20'($urandom_range(0, scale));
    endfunction

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Ramp sum far beyond the total time: negative denominator latched
        // while the elapsed time stays at zero.
        write_reg(REG_START, {20'h80000, 20'h7FFFF, 20'h00000});
        write_reg(REG_END, {20'h7FFFF, 20'h80000, 20'hFFFFF});
        write_reg(REG_TOTAL, 60'd1);
        write_reg(REG_UP, 60'h3FFFFFF);
        write_reg(REG_DOWN, 60'h3FFFFFF);
        send_tick(20'd0);
        send_tick(20'd0);
        drain();

        // Longest move; the next tick relatches the denominator.
        write_reg(REG_TOTAL, 60'h3FFFFFF);
        write_reg(REG_UP, 60'd1);
        write_reg(REG_DOWN, 60'd1);
        send_tick(20'd0);
        drain();
        write_reg(REG_UP, 60'd16777216);
        write_reg(REG_DOWN, 60'd16777216);
        send_tick(20'd0);
        send_tick(20'd1);
        send_tick(20'hFFFFF);
        send_tick(20'h55555);
        send_tick(20'hAAAAA);
        send_tick(20'd0);
        send_tick(20'd1);
        drain();

        // Random phases with live register changes mid-move.
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_START, rand_orient());
            write_reg(REG_END, rand_orient());
            case (ph)
                0:
                begin
                    write_reg(REG_UP, 60'd20000000);
                    write_reg(REG_DOWN, 60'd1);
                end
                1:
                begin
                    write_reg(REG_UP, 60'd30000000);
                    write_reg(REG_DOWN, 60'd50000000);
                end
                2:
                begin
                    write_reg(REG_TOTAL, 60'd60000000);
                    write_reg(REG_DOWN, 60'd25000000);
                end
                default:
                begin
                    write_reg(REG_TOTAL, 60'd90000000 & 60'h3FFFFFF);
                    write_reg(REG_UP, 60'($urandom_range(1, 30000000)));
                end
            endcase
            steady = (ph == 1);
            for (int n = 0; n < 150; n++)
            begin
                if (ph == 2 && n == 40)
                    hold_off = 300;
                if (ph == 0 && n == 75)
                begin
                    // Sender waits until every result has come back.
                    @(negedge clk);
                    tick_bus.valid = 1'b0;
                    wait (sb.pending.size() == 0);
                end
                send_tick(rand_delta(ph == 3 ? 1048575 : 180000));
            end
            steady = 1'b0;
            drain();
        end

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #16000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

`default_nettype wire
